// File: hdl/riscv_branch_target_decode_defines.svh
// Assertion macros shared by the branch target decoder RTL.
`ifndef RISCV_BRANCH_TARGET_DECODE_DEFINES_SVH
`define RISCV_BRANCH_TARGET_DECODE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RBTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RBTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rbtd_pkg.sv
// Types and decode constants for the branch target decoder.
`timescale 1ns / 1ps

package rbtd_pkg;

    // Major opcodes and match masks of the 32-bit forms.
    localparam logic [6:0]  OPC_JAL      = 7'h6f;
    localparam logic [6:0]  OPC_BRANCH   = 7'h63;
    localparam logic [31:0] MASK_JALR    = 32'h0000_707f;
    localparam logic [31:0] MATCH_JALR   = 32'h0000_0067;
    localparam logic [2:0]  F3_RSVD_A    = 3'd2;
    localparam logic [2:0]  F3_RSVD_B    = 3'd3;

    // Match masks of the compressed forms.
    localparam logic [15:0] MASK_C_TOP   = 16'he003;
    localparam logic [15:0] MATCH_C_J    = 16'ha001;
    localparam logic [15:0] MATCH_C_BEQZ = 16'hc001;
    localparam logic [15:0] MATCH_C_BNEZ = 16'he001;
    localparam logic [15:0] MASK_C_JR    = 16'hf07f;
    localparam logic [15:0] MATCH_C_JR   = 16'h8002;
    localparam logic [15:0] MATCH_C_JALR = 16'h9002;

    // Instruction lengths that decode.
    localparam logic [3:0]  LEN_FULL     = 4'd4;
    localparam logic [3:0]  LEN_HALF     = 4'd2;

    // Decode flags that travel with an item down the pipeline.
    typedef struct packed {
        logic       branch;
        logic       uncond;
        logic       uses_base;
        logic [4:0] base_index;
    } t_ctrl;

endpackage

// File: hdl/rbtd_in_if.sv
// Input channel of the branch target decoder: instruction, length, pc and rs1 value.
`timescale 1ns / 1ps

interface rbtd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] insn_word;
    logic [3:0]  insn_length;
    logic [63:0] pc_addr;
    logic [63:0] base_value;

    modport source (output valid, output insn_word, output insn_length,
                    output pc_addr, output base_value, input ready);
    modport sink   (input valid, input insn_word, input insn_length,
                    input pc_addr, input base_value, output ready);
endinterface

// File: hdl/rbtd_out_if.sv
// Result channel of the branch target decoder: flags, target and rs1 index.
`timescale 1ns / 1ps

interface rbtd_out_if;
    logic        valid;
    logic        ready;
    logic        branch_flag;
    logic        uncond_flag;
    logic [63:0] jump_target;
    logic        uses_base;
    logic [4:0]  base_index;

    modport source (output valid, output branch_flag, output uncond_flag,
                    output jump_target, output uses_base, output base_index,
                    input ready);
    modport sink   (input valid, input branch_flag, input uncond_flag,
                    input jump_target, input uses_base, input base_index,
                    output ready);
endinterface

// File: hdl/riscv_branch_target_decode.sv
// RISC-V RV64IC branch and jump target decoder. Each transfer on i_in carries one
// instruction word with its byte length, its pc and the value of its rs1 register;
// each transfer on o_out gives one result: branch and unconditional flags, the rs1
// index, whether the target comes from rs1, and the 64-bit target (zero and all
// flags clear for anything that is not jal, jalr, a conditional branch, c.j, c.jr,
// c.jalr, c.beqz or c.bnez; lengths other than 2 and 4 never decode). The block
// takes one instruction every cycle while the consumer does not stall. Each item
// passes through the registered stages in order before it reaches o_out:
// stage one decodes and builds the immediate, stage two adds the low 32 bits,
// stage three adds the high 32 bits and holds the result for the consumer. A
// stalled consumer backs the pipeline up stage by stage.
`timescale 1ns / 1ps
`include "riscv_branch_target_decode_defines.svh"

module riscv_branch_target_decode (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbtd_in_if.sink   i_in,
    rbtd_out_if.source o_out
);
    import rbtd_pkg::*;

    // Stage valid bits.
    logic r_v1, r_v2, r_v3;
    logic s1_free, s2_free, s3_free;

    // Stage one registers.
    t_ctrl       r1_ctrl;
    logic [63:0] r1_addend;
    logic [63:0] r1_offset;

    // Stage two registers.
    t_ctrl       r2_ctrl;
    logic [31:0] r2_lo;
    logic        r2_carry;
    logic [31:0] r2_addend_hi;
    logic [31:0] r2_offset_hi;

    // Stage three (output) registers.
    t_ctrl       r3_ctrl;
    logic [63:0] r3_target;

    // Decode signals.
    t_ctrl       n_ctrl;
    logic [63:0] n_addend;
    logic [63:0] n_offset;
    logic [15:0] half;
    logic [4:0]  rs1_full;
    logic [4:0]  rs1_half;
    logic [20:0] imm_jal;
    logic [11:0] imm_jalr;
    logic [12:0] imm_br;
    logic [8:0]  imm_cb;
    logic [11:0] imm_cj;
    logic        is_full, is_half;
    logic        dec_jal, dec_jalr, dec_br, dec_cb, dec_cjr, dec_cj;

    logic [32:0] sum_lo;
    logic [31:0] sum_hi;
    logic [63:0] n_target;

    // Ready chain: a stage can load when it is empty or its content moves on.
    assign s3_free    = !r_v3 || o_out.ready;
    assign s2_free    = !r_v2 || s3_free;
    assign s1_free    = !r_v1 || s2_free;
    assign i_in.ready = s1_free;

    // Field extraction and immediate assembly.
    always_comb begin
        half     = i_in.insn_word[15:0];
        rs1_full = i_in.insn_word[19:15];
        rs1_half = half[11:7];
        imm_jal  = {i_in.insn_word[31], i_in.insn_word[19:12], i_in.insn_word[20],
                    i_in.insn_word[30:21], 1'b0};
        imm_jalr = i_in.insn_word[31:20];
        imm_br   = {i_in.insn_word[31], i_in.insn_word[7], i_in.insn_word[30:25],
                    i_in.insn_word[11:8], 1'b0};
        imm_cb   = {half[12], half[6:5], half[2], half[11:10], half[4:3], 1'b0};
        imm_cj   = {half[12], half[8], half[10:9], half[6], half[7], half[2],
                    half[11], half[5:3], 1'b0};
    end

    // Instruction classification.
    always_comb begin
        is_full  = (i_in.insn_length == LEN_FULL);
        is_half  = (i_in.insn_length == LEN_HALF);
        dec_jal  = is_full && (i_in.insn_word[6:0] == OPC_JAL);
        dec_jalr = is_full && ((i_in.insn_word & MASK_JALR) == MATCH_JALR);
        dec_br   = is_full && (i_in.insn_word[6:0] == OPC_BRANCH)
                   && (i_in.insn_word[14:12] != F3_RSVD_A)
                   && (i_in.insn_word[14:12] != F3_RSVD_B);
        dec_cb   = is_half && (((half & MASK_C_TOP) == MATCH_C_BEQZ)
                   || ((half & MASK_C_TOP) == MATCH_C_BNEZ));
        dec_cjr  = is_half && (((half & MASK_C_JR) == MATCH_C_JR)
                   || ((half & MASK_C_JR) == MATCH_C_JALR)) && (rs1_half != 5'd0);
        dec_cj   = is_half && ((half & MASK_C_TOP) == MATCH_C_J);
    end

    // Flags, addend and sign-extended offset for the item entering stage one.
    always_comb begin
        n_ctrl.branch     = dec_jal || dec_jalr || dec_br || dec_cb || dec_cjr || dec_cj;
        n_ctrl.uncond     = dec_jal || dec_jalr || dec_cjr || dec_cj;
        n_ctrl.uses_base  = dec_jalr || dec_cjr;
        n_ctrl.base_index = 5'd0;
        n_offset          = 64'd0;
        if (dec_jalr || dec_br) begin
            n_ctrl.base_index = rs1_full;
        end else if (dec_cjr) begin
            n_ctrl.base_index = rs1_half;
        end else if (dec_cb) begin
            n_ctrl.base_index = {2'b01, half[9:7]};
        end
        if (dec_jal) begin
            n_offset = {{43{imm_jal[20]}}, imm_jal};
        end else if (dec_jalr) begin
            n_offset = {{52{imm_jalr[11]}}, imm_jalr};
        end else if (dec_br) begin
            n_offset = {{51{imm_br[12]}}, imm_br};
        end else if (dec_cb) begin
            n_offset = {{55{imm_cb[8]}}, imm_cb};
        end else if (dec_cj) begin
            n_offset = {{52{imm_cj[11]}}, imm_cj};
        end
        if (!n_ctrl.branch) begin
            n_addend = 64'd0;
        end else if (n_ctrl.uses_base) begin
            n_addend = i_in.base_value;
        end else begin
            n_addend = i_in.pc_addr;
        end
    end

    // Stage one registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_free) begin
            r_v1 <= i_in.valid;
        end
        if (s1_free && i_in.valid) begin
            r1_ctrl   <= n_ctrl;
            r1_addend <= n_addend;
            r1_offset <= n_offset;
        end
    end

    // Low half of the target add.
    assign sum_lo = {1'b0, r1_addend[31:0]} + {1'b0, r1_offset[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_free) begin
            r_v2 <= r_v1;
        end
        if (s2_free && r_v1) begin
            r2_ctrl      <= r1_ctrl;
            r2_lo        <= sum_lo[31:0];
            r2_carry     <= sum_lo[32];
            r2_addend_hi <= r1_addend[63:32];
            r2_offset_hi <= r1_offset[63:32];
        end
    end

    // High half of the target add; register-based targets drop bit 0.
    always_comb begin
        sum_hi   = r2_addend_hi + r2_offset_hi + {31'd0, r2_carry};
        n_target = {sum_hi, r2_lo[31:1], r2_lo[0] && !r2_ctrl.uses_base};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (s3_free) begin
            r_v3 <= r_v2;
        end
        if (s3_free && r_v2) begin
            r3_ctrl   <= r2_ctrl;
            r3_target <= n_target;
        end
    end

    // Result channel.
    assign o_out.valid       = r_v3;
    assign o_out.branch_flag = r3_ctrl.branch;
    assign o_out.uncond_flag = r3_ctrl.uncond;
    assign o_out.uses_base   = r3_ctrl.uses_base;
    assign o_out.base_index  = r3_ctrl.base_index;
    assign o_out.jump_target = r3_target;

    // Checks on the decode and pipeline logic.
    `RBTD_ASSERT_NOW(a_nonbranch_zero, i_clk, i_rst_n, r_v3 && !r3_ctrl.branch, (r3_target == 64'd0) && !r3_ctrl.uncond && !r3_ctrl.uses_base && (r3_ctrl.base_index == 5'd0), "non-branch result is not all zero")
    `RBTD_ASSERT_NOW(a_flag_order, i_clk, i_rst_n, r_v3, (!r3_ctrl.uses_base || r3_ctrl.uncond) && (!r3_ctrl.uncond || r3_ctrl.branch), "inconsistent branch flags")
    `RBTD_ASSERT_NOW(a_reg_target_even, i_clk, i_rst_n, r_v3 && r3_ctrl.uses_base, !r3_target[0], "register-based target is odd")
    `RBTD_ASSERT_NEXT(a_stage2_hold, i_clk, i_rst_n, r_v2 && !s3_free, r_v2 && $stable(r2_lo) && $stable(r2_ctrl), "stage two changed while stalled")

endmodule

// File: sim/tb_riscv_branch_target_decode.sv
// Self-checking testbench for the branch target decoder with random handshake gaps.
`timescale 1ns / 1ps

module tb_riscv_branch_target_decode;
    import rbtd_pkg::*;

    // Cycles of silence on both channels before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Cycles to keep watching the result channel after the last expected result.
    localparam int unsigned DRAIN_CYCLES = 8;
    // Number of random instructions after the directed part.
    localparam int unsigned RANDOM_ITEMS = 900;

    // Function-3 codes of the conditional branches and of jalr.
    typedef enum logic [2:0] {
        F3_BEQ  = 3'd0,
        F3_BNE  = 3'd1,
        F3_BLT  = 3'd4,
        F3_BGE  = 3'd5,
        F3_BLTU = 3'd6,
        F3_BGEU = 3'd7
    } branch_f3_e;
    localparam logic [2:0] F3_JALR = MATCH_JALR[14:12];

    // One decoded result as seen on the output channel.
    typedef struct packed {
        logic        branch;
        logic        uncond;
        logic [63:0] target;
        logic        uses_base;
        logic [4:0]  index;
    } decode_result_t;

    // Keeps the decoded results still owed by the block and checks them in order.
    class branch_target_scoreboard;
        decode_result_t pending_q[$];
        int unsigned    mismatches;
        int unsigned    checked;
        int unsigned    branches;
        int unsigned    reg_targets;

        // Decode one instruction the way the block must.
        function decode_result_t decode_target(logic [31:0] w, logic [3:0] len,
                                               logic [63:0] pc, logic [63:0] base);
            decode_result_t r;
            logic [15:0]    h;
            logic [20:0]    off21;
            logic [12:0]    off13;
            logic [11:0]    off12;
            logic [8:0]     off9;
            r = '0;
            h = w[15:0];
            if (len == LEN_FULL) begin
                if (w[6:0] == OPC_JAL) begin
                    off21 = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                    r.branch = 1'b1;
                    r.uncond = 1'b1;
                    r.target = pc + {{43{off21[20]}}, off21};
                end else if ((w & MASK_JALR) == MATCH_JALR) begin
                    r.branch    = 1'b1;
                    r.uncond    = 1'b1;
                    r.uses_base = 1'b1;
                    r.index     = w[19:15];
                    r.target    = (base + {{52{w[31]}}, w[31:20]}) & ~64'd1;
                end else if (w[6:0] == OPC_BRANCH && w[14:12] != F3_RSVD_A
                             && w[14:12] != F3_RSVD_B) begin
                    off13    = {w[31], w[7], w[30:25], w[11:8], 1'b0};
                    r.branch = 1'b1;
                    r.index  = w[19:15];
                    r.target = pc + {{51{off13[12]}}, off13};
                end
            end else if (len == LEN_HALF) begin
                if ((h & MASK_C_TOP) == MATCH_C_BEQZ || (h & MASK_C_TOP) == MATCH_C_BNEZ) begin
                    off9     = {h[12], h[6:5], h[2], h[11:10], h[4:3], 1'b0};
                    r.branch = 1'b1;
                    r.index  = {2'b01, h[9:7]};
                    r.target = pc + {{55{off9[8]}}, off9};
                end else if (((h & MASK_C_JR) == MATCH_C_JR || (h & MASK_C_JR) == MATCH_C_JALR)
                             && h[11:7] != 5'd0) begin
                    r.branch    = 1'b1;
                    r.uncond    = 1'b1;
                    r.uses_base = 1'b1;
                    r.index     = h[11:7];
                    r.target    = base & ~64'd1;
                end else if ((h & MASK_C_TOP) == MATCH_C_J) begin
                    off12    = {h[12], h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
                    r.branch = 1'b1;
                    r.uncond = 1'b1;
                    r.target = pc + {{52{off12[11]}}, off12};
                end
            end
            return r;
        endfunction

        // Record the result owed for an instruction transfer.
        function void note_input(logic [31:0] w, logic [3:0] len,
                                 logic [63:0] pc, logic [63:0] base);
            pending_q.push_back(decode_target(w, len, pc, base));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                $error("%s mismatch: expected %h, got %h", name, want, got);
            end
        endfunction

        // Check one result transfer against the oldest owed result.
        function void check_result(decode_result_t got);
            decode_result_t want;
            if (pending_q.size() == 0) begin
                mismatches++;
                $error("result with no instruction outstanding: target %h", got.target);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (want.branch)
                branches++;
            if (want.uses_base)
                reg_targets++;
            compare_field("branch_flag", 64'(want.branch), 64'(got.branch));
            compare_field("uncond_flag", 64'(want.uncond), 64'(got.uncond));
            compare_field("jump_target", want.target, got.target);
            compare_field("uses_base", 64'(want.uses_base), 64'(got.uses_base));
            compare_field("base_index", 64'(want.index), 64'(got.index));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rbtd_in_if  in_ch();
    rbtd_out_if out_ch();

    branch_target_scoreboard sb = new;

    int unsigned src_quiet;
    int unsigned snk_quiet;
    int unsigned idle_cycles;

    riscv_branch_target_decode i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Instruction encoders, taking the immediate as the architectural byte offset.
    function automatic logic [31:0] enc_jal(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    function automatic logic [31:0] enc_jalr(logic [11:0] imm, logic [4:0] rs1,
                                             logic [2:0] f3, logic [4:0] rd);
        return {imm, rs1, f3, rd, MATCH_JALR[6:0]};
    endfunction

    function automatic logic [31:0] enc_branch(logic [2:0] f3, logic [4:0] rs1,
                                               logic [4:0] rs2, logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [15:0] enc_cb(logic [15:0] match, logic [2:0] rs1p,
                                           logic [8:0] imm);
        return match | {3'b0, imm[8], imm[4:3], rs1p, imm[7:6], imm[2:1], imm[5], 2'b0};
    endfunction

    function automatic logic [15:0] enc_cj(logic [11:0] imm);
        return MATCH_C_J | {3'b0, imm[11], imm[4], imm[9:8], imm[10], imm[6], imm[7],
                            imm[3:1], imm[5], 2'b0};
    endfunction

    function automatic logic [15:0] enc_cr(logic [15:0] match, logic [4:0] rs1,
                                           logic [4:0] rs2);
        return match | {4'b0, rs1, rs2, 2'b0};
    endfunction

    // Wait before the next transfer, with occasional stretches of no waiting at all.
    function automatic int unsigned draw_wait(inout int unsigned quiet_left);
        if (quiet_left != 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // Addresses and register values, biased toward the edges of the 64-bit range.
    function automatic logic [63:0] draw_addr();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7fff_ffff_ffff_ffff;
            4: return {32'h0, $urandom};
            5: return {$urandom, 28'hfff_ffff, 4'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Build one random instruction. Low picks are mostly well-formed branches and
    // jumps with random fields; higher picks are near misses, raw noise and odd lengths.
    function automatic void make_random_insn(input int unsigned pick,
                                             output logic [31:0] w, output logic [3:0] len);
        logic [31:0] noise;
        logic [31:0] hi;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        noise = $urandom;
        hi    = $urandom;
        len   = LEN_FULL;
        if (pick < 12) begin
            w = enc_jal(noise[20:0], noise[25:21]);
        end else if (pick < 24) begin
            f3 = ($urandom_range(0, 7) == 0) ? 3'($urandom) : F3_JALR;
            w  = enc_jalr(noise[11:0], noise[16:12], f3, noise[21:17]);
        end else if (pick < 44) begin
            w = enc_branch(3'($urandom), noise[4:0], noise[9:5], noise[22:10]);
        end else if (pick < 54) begin
            w   = {hi[15:0], enc_cb(noise[0] ? MATCH_C_BEQZ : MATCH_C_BNEZ,
                                    noise[3:1], noise[12:4])};
            len = LEN_HALF;
        end else if (pick < 62) begin
            w   = {hi[15:0], enc_cj(noise[11:0])};
            len = LEN_HALF;
        end else if (pick < 72) begin
            rs1 = ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
            rs2 = ($urandom_range(0, 7) == 0) ? noise[4:0] : 5'd0;
            w   = {hi[15:0], enc_cr(noise[5] ? MATCH_C_JR : MATCH_C_JALR, rs1, rs2)};
            len = LEN_HALF;
        end else if (pick < 82) begin
            // An instruction from the low picks with one bit flipped.
            make_random_insn($urandom_range(0, 71), w, len);
            w[$urandom_range(0, (len == LEN_HALF) ? 15 : 31)] ^= 1'b1;
        end else if (pick < 90) begin
            w   = noise;
            len = noise[0] ? LEN_HALF : LEN_FULL;
        end else begin
            w   = noise;
            len = 4'($urandom_range(0, 15));
        end
        if ($urandom_range(0, 31) == 0)
            len = 4'($urandom_range(0, 15));
    endfunction

    // Present one instruction and hold it until the block takes the transfer.
    task automatic send_insn(logic [31:0] w, logic [3:0] len,
                             logic [63:0] pc, logic [63:0] base);
        int unsigned gap;
        gap = draw_wait(src_quiet);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.insn_word   <= w;
        in_ch.insn_length <= len;
        in_ch.pc_addr     <= pc;
        in_ch.base_value  <= base;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sb.note_input(w, len, pc, base);
    endtask

    // Result side: stall at random before each transfer.
    initial begin : result_sink
        int unsigned stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            stall = draw_wait(snk_quiet);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid)
                @(posedge i_clk);
        end
    end

    // Check every result transfer.
    always @(posedge i_clk) begin : result_monitor
        decode_result_t got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.branch    = out_ch.branch_flag;
            got.uncond    = out_ch.uncond_flag;
            got.target    = out_ch.jump_target;
            got.uses_base = out_ch.uses_base;
            got.index     = out_ch.base_index;
            sb.check_result(got);
        end
    end

    // Stop a run in which neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, sb.pending_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Reset, directed cases, random stream, then drain and report.
    initial begin : stimulus
        logic [31:0] w;
        logic [3:0]  len;
        src_quiet         = 0;
        snk_quiet         = 0;
        idle_cycles       = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.insn_word   <= '0;
        in_ch.insn_length <= '0;
        in_ch.pc_addr     <= '0;
        in_ch.base_value  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // jal at the largest offsets, wrapping past both ends of the address space.
        send_insn(enc_jal(21'h0f_fffe, 5'd1), LEN_FULL, 64'hffff_ffff_ffff_fff0, '0);
        send_insn(enc_jal(21'h10_0000, 5'd0), LEN_FULL, '0, '1);
        // jalr: negative and largest offsets, bit 0 cleared, and a bad function-3.
        send_insn(enc_jalr(12'hfff, 5'd31, F3_JALR, 5'd1), LEN_FULL, 64'h1234, 64'h1);
        send_insn(enc_jalr(12'h7ff, 5'd1, F3_JALR, 5'd0), LEN_FULL, '0, '1);
        send_insn(enc_jalr(12'h800, 5'd7, ~F3_JALR, 5'd1), LEN_FULL, '1, '1);
        // Every conditional branch, then the two reserved function-3 codes.
        send_insn(enc_branch(F3_BEQ, 5'd3, 5'd4, 13'h0ffe), LEN_FULL, '1, '0);
        send_insn(enc_branch(F3_BNE, 5'd31, 5'd0, 13'h1000), LEN_FULL, '0, '0);
        send_insn(enc_branch(F3_BLT, 5'd0, 5'd31, 13'h0000), LEN_FULL, 64'h8000, '0);
        send_insn(enc_branch(F3_BGE, 5'd16, 5'd1, 13'h0802), LEN_FULL, 64'hffff_fffe, '0);
        send_insn(enc_branch(F3_BLTU, 5'd1, 5'd2, 13'h1ffe), LEN_FULL, 64'h100, '0);
        send_insn(enc_branch(F3_BGEU, 5'd8, 5'd9, 13'h0554), LEN_FULL, '1, '1);
        send_insn(enc_branch(F3_RSVD_A, 5'd5, 5'd6, 13'h0010), LEN_FULL, 64'h40, '0);
        send_insn(enc_branch(F3_RSVD_B, 5'd5, 5'd6, 13'h0010), LEN_FULL, 64'h40, '0);
        // Compressed conditional branches and c.j at their extreme offsets.
        send_insn({16'hffff, enc_cb(MATCH_C_BEQZ, 3'd0, 9'h100)}, LEN_HALF, '0, '0);
        send_insn({16'h0000, enc_cb(MATCH_C_BNEZ, 3'd7, 9'h0fe)}, LEN_HALF, '1, '0);
        send_insn({16'h0000, enc_cj(12'h7fe)}, LEN_HALF, '1, '0);
        send_insn({16'hffff, enc_cj(12'h800)}, LEN_HALF, '0, '1);
        // Register jumps, the reserved and breakpoint encodings with register zero,
        // and a register move that only resembles c.jr.
        send_insn({16'h0000, enc_cr(MATCH_C_JR, 5'd5, 5'd0)}, LEN_HALF, '0, '1);
        send_insn({16'h0000, enc_cr(MATCH_C_JALR, 5'd31, 5'd0)}, LEN_HALF, '0,
                  64'h8000_0000_0000_0001);
        send_insn({16'h0000, enc_cr(MATCH_C_JR, 5'd0, 5'd0)}, LEN_HALF, '0, '1);
        send_insn({16'h0000, enc_cr(MATCH_C_JALR, 5'd0, 5'd0)}, LEN_HALF, '0, '1);
        send_insn({16'h0000, enc_cr(MATCH_C_JR, 5'd5, 5'd6)}, LEN_HALF, '0, '1);
        // Lengths that disagree with the encoding, and lengths that never decode.
        send_insn(enc_jal(21'h00_0040, 5'd1), LEN_HALF, 64'h1000, '0);
        send_insn({16'h0000, enc_cj(12'h010)}, LEN_FULL, 64'h1000, '0);
        send_insn(enc_jal(21'h00_0040, 5'd1), 4'd0, 64'h1000, '0);
        send_insn(32'hffff_ffff, 4'd15, '1, '1);

        // Random stream.
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            make_random_insn($urandom_range(0, 99), w, len);
            send_insn(w, len, draw_addr(), draw_addr());
        end
        in_ch.valid <= 1'b0;

        // Let every owed result arrive, then watch for strays.
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d decoded instructions: %0d branches or jumps, %0d register-based.",
                 sb.checked, sb.branches, sb.reg_targets);
        $display("Mismatches found: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
